// ===== rtl/vtx_pkg.sv =====
// Shared types, reset matrix and binary32 arithmetic helpers for the vertex transform.
package vtx_pkg;

    localparam int NumLanes = 4;
    localparam int NumRegs  = 8;
    localparam int IdxW     = 3;
    localparam int Depth    = 8;

    localparam logic [31:0] CanonNan = 32'h7FC0_0000;

    localparam logic [63:0] RegReset [NumRegs] = '{
        64'h0000_0000_3F80_0000, 64'h0,
        64'h3F80_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_3F80_0000,
        64'h0, 64'h3F80_0000_0000_0000
    };

    typedef logic [31:0] flt_t;

    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               zero;
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        m;
    } mul_pre_t;

    typedef struct packed {
        logic               nan;
        logic               inf;
        logic               sign;
        logic signed [10:0] exp;
        logic [49:0]        m;
    } add_pre_t;

    // value = m * 2^(exp - 176); exp is the biased exponent when m[49] is set
    function automatic flt_t norm_round(input logic sign, input logic signed [10:0] exp,
                                        input logic [49:0] m);
        logic [5:0]         lz;
        logic [49:0]        n;
        logic signed [10:0] eb;
        logic signed [10:0] t;
        logic [5:0]         sh;
        logic               st;
        logic [23:0]        mant;
        logic               inc;
        logic [30:0]        mag;
        flt_t               r;
        // exact cancellation gives a zero of the chosen sign
        if (m == 50'b0)
            return {sign, 31'b0};
        lz = 6'd50;
        for (int i = 0; i < 50; i++)
            if (m[i])
                lz = 6'(49 - i);
        n  = m << lz;
        eb = exp - $signed({5'b0, lz});
        st = 1'b0;
        if (eb < 11'sd1)
        begin
            t  = 11'sd1 - eb;
            sh = (t > 11'sd50) ? 6'd50 : t[5:0];
            st = |(n & ((50'b1 << sh) - 50'b1));
            n  = n >> sh;
            eb = 11'sd0;
        end
        mant = n[49:26];
        inc  = n[25] & (st | (|n[24:0]) | mant[0]);
        if (eb >= 11'sd255)
            r = {sign, 8'hFF, 23'b0};
        else
        begin
            mag = {eb[7:0], mant[22:0]} + {30'b0, inc};
            r   = {sign, mag};
        end
        return r;
    endfunction

    function automatic mul_pre_t mul_pre(input flt_t a, input flt_t b);
        mul_pre_t p;
        logic     an, bn, ai, bi, az, bz;
        logic [7:0] ea, eb;
        logic [23:0] ma, mb;
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        az = (a[30:0] == 31'b0);
        bz = (b[30:0] == 31'b0);
        ea = (a[30:23] == 8'h0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'h0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'h0), a[22:0]};
        mb = {(b[30:23] != 8'h0), b[22:0]};
        p.nan  = an | bn | (ai & bz) | (bi & az);
        p.inf  = ai | bi;
        p.zero = az | bz;
        p.sign = a[31] ^ b[31];
        p.exp  = $signed({3'b0, ea}) + $signed({3'b0, eb}) - 11'sd126;
        p.m    = ma * mb;
        return p;
    endfunction

    function automatic flt_t mul_post(input mul_pre_t p);
        flt_t r;
        if (p.nan)
            r = CanonNan;
        else if (p.inf)
            r = {p.sign, 8'hFF, 23'b0};
        else if (p.zero)
            r = {p.sign, 31'b0};
        else
            r = norm_round(p.sign, p.exp, {p.m, 2'b0});
        return r;
    endfunction

    function automatic add_pre_t add_pre(input flt_t a, input flt_t b);
        add_pre_t p;
        logic     an, bn, ai, bi, swap;
        flt_t     hi, lo;
        logic [7:0] eh, el, d;
        logic [5:0] sh;
        logic [49:0] mh, ml, ms;
        logic        st;
        an = (a[30:23] == 8'hFF) && (a[22:0] != 23'b0);
        bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'b0);
        ai = (a[30:23] == 8'hFF) && (a[22:0] == 23'b0);
        bi = (b[30:23] == 8'hFF) && (b[22:0] == 23'b0);
        swap = (b[30:0] > a[30:0]);
        hi = swap ? b : a;
        lo = swap ? a : b;
        eh = (hi[30:23] == 8'h0) ? 8'd1 : hi[30:23];
        el = (lo[30:23] == 8'h0) ? 8'd1 : lo[30:23];
        d  = eh - el;
        sh = (d > 8'd50) ? 6'd50 : d[5:0];
        mh = {1'b0, (hi[30:23] != 8'h0), hi[22:0], 25'b0};
        ml = {1'b0, (lo[30:23] != 8'h0), lo[22:0], 25'b0};
        st = |(ml & ((50'b1 << sh) - 50'b1));
        ms = (ml >> sh) | {49'b0, st};
        p.nan  = an | bn | (ai & bi & (a[31] != b[31]));
        p.inf  = ai | bi;
        p.exp  = $signed({3'b0, eh}) + 11'sd1;
        p.m    = (a[31] == b[31]) ? (mh + ms) : (mh - ms);
        if (p.inf)
            p.sign = ai ? a[31] : b[31];
        else if (p.m == 50'b0)
            p.sign = (a[31] == b[31]) ? a[31] : 1'b0;
        else
            p.sign = hi[31];
        return p;
    endfunction

    function automatic flt_t add_post(input add_pre_t p);
        flt_t r;
        if (p.nan)
            r = CanonNan;
        else if (p.inf)
            r = {p.sign, 8'hFF, 23'b0};
        else
            r = norm_round(p.sign, p.exp, p.m);
        return r;
    endfunction

endpackage

// ===== rtl/vtx_lane.sv =====
// One output component: four products then three ordered sums, eight register stages.
module vtx_lane
    import vtx_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  flt_t vec [NumLanes],
    input  flt_t col [NumLanes],
    output flt_t res
);

    mul_pre_t mp_reg [NumLanes];
    flt_t     prod_reg [NumLanes];
    add_pre_t ap1_reg, ap2_reg, ap3_reg;
    flt_t     acc1_reg, acc2_reg, res_reg;
    flt_t     p2_s3_reg, p2_s4_reg;
    flt_t     p3_s3_reg, p3_s4_reg, p3_s5_reg, p3_s6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NumLanes; i++)
            begin
                mp_reg[i]   <= mul_pre(vec[i], col[i]);
                prod_reg[i] <= mul_post(mp_reg[i]);
            end
            ap1_reg   <= add_pre(prod_reg[0], prod_reg[1]);
            p2_s3_reg <= prod_reg[2];
            p3_s3_reg <= prod_reg[3];
            acc1_reg  <= add_post(ap1_reg);
            p2_s4_reg <= p2_s3_reg;
            p3_s4_reg <= p3_s3_reg;
            ap2_reg   <= add_pre(acc1_reg, p2_s4_reg);
            p3_s5_reg <= p3_s4_reg;
            acc2_reg  <= add_post(ap2_reg);
            p3_s6_reg <= p3_s5_reg;
            ap3_reg   <= add_pre(acc2_reg, p3_s6_reg);
            res_reg   <= add_post(ap3_reg);
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/vertex_transform_4x4_float.sv =====
// Top level: matrix registers, valid pipeline and four column lanes.
//  channel | direction | handshake          | payload
//  in      | in        | in_valid/in_stall   | in_x in_y in_z in_w
//  out     | out       | out_valid/out_stall | out_x out_y out_z out_w
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index cfg_data
// One item per cycle unless stalled; each multiply and add has a pre and post stage.
// The last lane stage is the output register; all stages advance together.
// An item waiting at the output under stall holds the pipe and stalls the input.
// Reset restores the identity matrix and empties the pipe.
module vertex_transform_4x4_float
    import vtx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [31:0]      in_x,
    input  logic [31:0]      in_y,
    input  logic [31:0]      in_z,
    input  logic [31:0]      in_w,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [31:0]      out_x,
    output logic [31:0]      out_y,
    output logic [31:0]      out_z,
    output logic [31:0]      out_w,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IdxW-1:0]  cfg_index,
    input  logic [63:0]      cfg_data
);

    logic [63:0]      row_reg [NumRegs];
    logic [Depth-1:0] vld_reg, vld_next;
    logic             en;
    flt_t             vec [NumLanes];
    flt_t             col [NumLanes][NumLanes];
    flt_t             res [NumLanes];

    assign cfg_ready = 1'b1;
    assign en        = !(vld_reg[Depth-1] && out_stall);
    assign in_stall  = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumRegs; i++)
                row_reg[i] <= RegReset[i];
        end
        else if (cfg_valid)
        begin
            row_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        vld_next = {vld_reg[Depth-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    assign vec[0] = in_x;
    assign vec[1] = in_y;
    assign vec[2] = in_z;
    assign vec[3] = in_w;

    // column j takes M[i][j] from register 2i + j/2, half j%2
    always_comb
    begin
        for (int j = 0; j < NumLanes; j++)
            for (int i = 0; i < NumLanes; i++)
                col[j][i] = (j % 2 == 1) ? row_reg[i*2 + j/2][63:32]
                                         : row_reg[i*2 + j/2][31:0];
    end

    for (genvar j = 0; j < NumLanes; j++)
    begin : g_lane
        vtx_lane u_lane (
            .clk (clk),
            .en  (en),
            .vec (vec),
            .col (col[j]),
            .res (res[j])
        );
    end

    assign out_valid = vld_reg[Depth-1];
    assign out_x     = res[0];
    assign out_y     = res[1];
    assign out_z     = res[2];
    assign out_w     = res[3];

endmodule

// ===== rtl/vtx_checker.sv =====
// Port-level checks for the vertex transform, bound to the top level.
module vtx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] out_x,
    input logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("item dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x))
        else $error("stalled item changed");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind vertex_transform_4x4_float vtx_checker u_vtx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .cfg_ready (cfg_ready)
);
